>>> hdl/mvns_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvns_pkg: shared types and constants for the vertex normal smoother
// Item, result and control types used by the datapath and the testbench.
// ----------------------------------------------------------------------------
package mvns_pkg;

   localparam int VertexCount    = 4096;
   localparam int VertexIdxW     = 12;
   localparam int FacesPerVertex = 6;
   localparam int TallyW         = 3;
   localparam int PosW           = 24;
   localparam int SumW           = 19;
   localparam int NormW          = 16;
   localparam int OneQ14         = 16384;

   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_TRI   = 2'd1,
      KIND_QUERY = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [1:0]            kind;
      logic [VertexIdxW-1:0] vertex_index;
      logic signed [PosW-1:0] pos_x;
      logic signed [PosW-1:0] pos_y;
      logic signed [PosW-1:0] pos_z;
      logic [VertexIdxW-1:0] corner_a;
      logic [VertexIdxW-1:0] corner_b;
      logic [VertexIdxW-1:0] corner_c;
   } req_type;

   typedef struct packed {
      logic signed [NormW-1:0] normal_x;
      logic signed [NormW-1:0] normal_y;
      logic signed [NormW-1:0] normal_z;
      logic [TallyW-1:0]       faces_counted;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PRD_A, ST_PRD_B, ST_PRD_C, ST_PRD_W,
      ST_EDGE, ST_CR0, ST_CR1, ST_CR2, ST_FN_START, ST_FN_WAIT,
      ST_SRD, ST_SWAIT, ST_SWR,
      ST_QRD, ST_QWAIT, ST_QN_WAIT, ST_RSP
   } state_type;

   typedef enum logic [2:0] {
      NS_IDLE, NS_SHIFT, NS_SQ, NS_SQRT, NS_DIV, NS_DONE
   } norm_state_type;

endpackage

>>> hdl/mvns_normalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvns_normalizer: multi-cycle vector normalizer
// Shifts magnitudes below 2^30, takes an integer square root of the squared
// length one bit per cycle, then divides each scaled component one bit per
// cycle with rounding to Q1.14.
// ----------------------------------------------------------------------------
module mvns_normalizer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [63:0]            vec_x,
   input  logic signed [63:0]            vec_y,
   input  logic signed [63:0]            vec_z,
   output logic                          done,
   output logic signed [mvns_pkg::NormW-1:0] unit_x,
   output logic signed [mvns_pkg::NormW-1:0] unit_y,
   output logic signed [mvns_pkg::NormW-1:0] unit_z
);
   import mvns_pkg::*;

   norm_state_type state_ff, state_in;
   logic [63:0] mag_ff [3];
   logic [63:0] mag_in [3];
   logic [2:0]  neg_ff, neg_in;
   logic [1:0]  idx_ff, idx_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] sq_ff, sq_in;
   logic [63:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [46:0] num_ff, num_in;
   logic [46:0] drem_ff, drem_in;
   logic [15:0] quo_ff [3];
   logic [15:0] quo_in [3];
   logic [15:0] q_ff, q_in;
   logic [61:0] prod;
   logic [65:0] trial;
   logic [47:0] dtrial;
   logic [63:0] maxm;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= NS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      idx_ff  <= idx_in;
      cnt_ff  <= cnt_in;
      sq_ff   <= sq_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      num_ff  <= num_in;
      drem_ff <= drem_in;
      quo_ff  <= quo_in;
      q_ff    <= q_in;
   end

   always_comb begin
      logic [63:0] m;
      m = mag_ff[idx_ff];
      prod = m[30:0] * m[30:0];
      maxm = mag_ff[0];
      if (mag_ff[1] > maxm) maxm = mag_ff[1];
      if (mag_ff[2] > maxm) maxm = mag_ff[2];
   end

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      sq_in    = sq_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      num_in   = num_ff;
      drem_in  = drem_ff;
      quo_in   = quo_ff;
      q_in     = q_ff;
      trial    = '0;
      dtrial   = '0;
      unique case (state_ff)
         NS_IDLE: begin
            if (start) begin
               neg_in[0] = vec_x[63];
               neg_in[1] = vec_y[63];
               neg_in[2] = vec_z[63];
               mag_in[0] = vec_x[63] ? 64'(-vec_x) : 64'(vec_x);
               mag_in[1] = vec_y[63] ? 64'(-vec_y) : 64'(vec_y);
               mag_in[2] = vec_z[63] ? 64'(-vec_z) : 64'(vec_z);
               state_in  = NS_SHIFT;
            end
         end
         // shift all magnitudes right one bit a cycle until below 2^30
         NS_SHIFT: begin
            if (maxm[63:30] != '0) begin
               mag_in[0] = mag_ff[0] >> 1;
               mag_in[1] = mag_ff[1] >> 1;
               mag_in[2] = mag_ff[2] >> 1;
            end else begin
               idx_in   = '0;
               sq_in    = '0;
               state_in = NS_SQ;
            end
         end
         // accumulate squares, one component a cycle
         NS_SQ: begin
            sq_in = sq_ff + 64'(prod);
            if (idx_ff == 2'd2) begin
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = 7'd32;
               state_in = NS_SQRT;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         // restoring square root, one result bit a cycle
         NS_SQRT: begin
            trial = {rem_ff[63:0], sq_ff[63:62]} - {32'd0, root_ff, 2'b01};
            if (!trial[65]) begin
               rem_in  = trial[63:0];
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               rem_in  = {rem_ff[61:0], sq_ff[63:62]};
               root_in = {root_ff[30:0], 1'b0};
            end
            sq_in  = {sq_ff[61:0], 2'b00};
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               idx_in   = '0;
               cnt_in   = 7'd0;
               state_in = NS_DIV;
            end
         end
         // long division of m*16384 + len/2 by len, one bit a cycle
         NS_DIV: begin
            if (root_ff == '0) begin
               quo_in[0] = '0; quo_in[1] = '0; quo_in[2] = '0;
               state_in  = NS_DONE;
            end else if (cnt_ff == 7'd0) begin
               num_in  = {mag_ff[idx_ff][29:0], 14'd0} + 47'(root_ff[31:1]);
               drem_in = '0;
               q_in    = '0;
               cnt_in  = 7'd47;
            end else begin
               dtrial = {drem_ff, num_ff[46]} - {16'd0, root_ff};
               if (!dtrial[47]) begin
                  drem_in = dtrial[46:0];
                  q_in    = {q_ff[14:0], 1'b1};
               end else begin
                  drem_in = {drem_ff[45:0], num_ff[46]};
                  q_in    = {q_ff[14:0], 1'b0};
               end
               num_in = {num_ff[45:0], 1'b0};
               cnt_in = cnt_ff - 7'd1;
               if (cnt_ff == 7'd1) begin
                  quo_in[idx_ff] = q_in;
                  if (idx_ff == 2'd2) begin
                     state_in = NS_DONE;
                  end else begin
                     idx_in = idx_ff + 2'd1;
                  end
               end
            end
         end
         NS_DONE: state_in = NS_IDLE;
         default: state_in = NS_IDLE;
      endcase
   end

   assign done   = (state_ff == NS_DONE);
   assign unit_x = neg_ff[0] ? -$signed(quo_ff[0]) : $signed(quo_ff[0]);
   assign unit_y = neg_ff[1] ? -$signed(quo_ff[1]) : $signed(quo_ff[1]);
   assign unit_z = neg_ff[2] ? -$signed(quo_ff[2]) : $signed(quo_ff[2]);

endmodule

>>> hdl/mvns_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvns_store: position and sum/tally memories
// Position memory is undefined until written. Sum/tally memory is cleared
// by a sweep after reset; ready is low until the sweep ends.
// ----------------------------------------------------------------------------
module mvns_store (
   input  logic                            clock,
   input  logic                            reset,
   output logic                            ready,
   input  logic                            pos_we,
   input  logic [mvns_pkg::VertexIdxW-1:0] pos_addr,
   input  logic [3*mvns_pkg::PosW-1:0]     pos_wdata,
   output logic [3*mvns_pkg::PosW-1:0]     pos_rdata,
   input  logic                            sum_we,
   input  logic [mvns_pkg::VertexIdxW-1:0] sum_addr,
   input  logic [3*mvns_pkg::SumW+mvns_pkg::TallyW-1:0] sum_wdata,
   output logic [3*mvns_pkg::SumW+mvns_pkg::TallyW-1:0] sum_rdata
);
   import mvns_pkg::*;

   localparam int SW = 3*SumW + TallyW;

   logic [3*PosW-1:0] pos_mem [VertexCount];
   logic [SW-1:0]     sum_mem [VertexCount];
   logic              clr_ff;
   logic [VertexIdxW-1:0] clr_idx_ff;

   // clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_idx_ff <= '0;
      end else if (clr_ff) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
         if (clr_idx_ff == VertexIdxW'(VertexCount-1)) clr_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pos_we) pos_mem[pos_addr] <= pos_wdata;
      pos_rdata <= pos_mem[pos_addr];
   end

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         sum_mem[clr_idx_ff] <= '0;
      end else if (sum_we) begin
         sum_mem[sum_addr] <= sum_wdata;
      end
      sum_rdata <= sum_mem[sum_addr];
   end

   assign ready = !clr_ff;

endmodule

>>> hdl/mesh_vertex_normal_smoother.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_vertex_normal_smoother: smooth vertex normal accumulator
// Loads positions, accumulates capped face normals, answers normal queries.
// ----------------------------------------------------------------------------
// Usage: drive req_word with start high while busy is low; the word is taken
// at that edge. kind 0 loads a position, kind 1 adds a triangle, kind 2
// queries a vertex. A query answers with one rsp_word marked by rsp_valid
// for a single cycle; the receiver cannot stall and must take it.
// A load writes the position. A triangle reads three positions, forms the
// cross product in multiply states CR0, CR1 and CR2, normalizes it (shift
// search, square root, three divisions), then does three read-modify-writes
// on the one-port sum memory, each through states SRD, SWAIT and SWR. A query
// reads the sum and normalizes it, then shows the result.
// One item is in work at a time; busy stays high until it is done.
// After reset a clearing pass zeroes the sum and tally memory; busy is high
// during it.
// ----------------------------------------------------------------------------
module mesh_vertex_normal_smoother (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  mvns_pkg::req_type  req_word,
   output logic               rsp_valid,
   output mvns_pkg::rsp_type  rsp_word
);
   import mvns_pkg::*;

   localparam int SW = 3*SumW + TallyW;

   state_type state_ff, state_in;
   req_type   req_ff;
   logic signed [PosW:0] e0_ff [3];
   logic signed [PosW:0] e0_in [3];
   logic signed [PosW:0] e1_ff [3];
   logic signed [PosW:0] e1_in [3];
   logic signed [3*PosW-1:0] pa_ff, pb_ff;
   logic signed [3*PosW-1:0] pa_in, pb_in;
   logic signed [63:0] cr_ff [3];
   logic signed [63:0] cr_in [3];
   logic signed [63:0] pm0_ff, pm1_ff, pm0_in, pm1_in;
   logic signed [NormW-1:0] fn_ff [3];
   logic signed [NormW-1:0] fn_in [3];
   logic [1:0] ci_ff, ci_in;
   logic [TallyW-1:0] qtally_ff, qtally_in;
   rsp_type rsp_ff, rsp_in;
   logic valid_ff, valid_in;

   logic store_ready;
   logic pos_we;
   logic [VertexIdxW-1:0] pos_addr, sum_addr;
   logic [3*PosW-1:0] pos_rdata;
   logic sum_we;
   logic [SW-1:0] sum_wdata, sum_rdata;
   logic norm_start;
   logic norm_done;
   logic signed [63:0] nvx, nvy, nvz;
   logic signed [NormW-1:0] ux, uy, uz;
   logic [VertexIdxW-1:0] cur_corner;

   mvns_store u_store (
      .clock(clock), .reset(reset), .ready(store_ready),
      .pos_we(pos_we), .pos_addr(pos_addr), .pos_wdata(
         {req_ff.pos_x, req_ff.pos_y, req_ff.pos_z}),
      .pos_rdata(pos_rdata),
      .sum_we(sum_we), .sum_addr(sum_addr), .sum_wdata(sum_wdata),
      .sum_rdata(sum_rdata)
   );

   mvns_normalizer u_norm (
      .clock(clock), .reset(reset), .start(norm_start),
      .vec_x(nvx), .vec_y(nvy), .vec_z(nvz), .done(norm_done),
      .unit_x(ux), .unit_y(uy), .unit_z(uz)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      if (start && !busy) req_ff <= req_word;
      e0_ff  <= e0_in;
      e1_ff  <= e1_in;
      pa_ff  <= pa_in;
      pb_ff  <= pb_in;
      cr_ff  <= cr_in;
      pm0_ff <= pm0_in;
      pm1_ff <= pm1_in;
      fn_ff  <= fn_in;
      ci_ff  <= ci_in;
      qtally_ff <= qtally_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      unique case (ci_ff)
         2'd0:    cur_corner = req_ff.corner_a;
         2'd1:    cur_corner = req_ff.corner_b;
         default: cur_corner = req_ff.corner_c;
      endcase
   end

   always_comb begin
      logic signed [SumW-1:0] s0, s1, s2;
      logic [TallyW-1:0] t;
      state_in  = state_ff;
      e0_in = e0_ff; e1_in = e1_ff; pa_in = pa_ff; pb_in = pb_ff;
      cr_in = cr_ff; pm0_in = pm0_ff; pm1_in = pm1_ff;
      fn_in = fn_ff; ci_in = ci_ff; qtally_in = qtally_ff;
      rsp_in = rsp_ff; valid_in = 1'b0;
      pos_we = 1'b0; pos_addr = req_ff.vertex_index;
      sum_we = 1'b0; sum_addr = req_ff.vertex_index; sum_wdata = sum_rdata;
      norm_start = 1'b0;
      nvx = cr_ff[0]; nvy = cr_ff[1]; nvz = cr_ff[2];
      s0 = sum_rdata[SW-1 -: SumW];
      s1 = sum_rdata[SW-1-SumW -: SumW];
      s2 = sum_rdata[SW-1-2*SumW -: SumW];
      t  = sum_rdata[TallyW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (start && store_ready) begin
               unique case (kind_type'(req_word.kind))
                  KIND_LOAD:  state_in = ST_PRD_W;
                  KIND_TRI:   state_in = ST_PRD_A;
                  KIND_QUERY: state_in = ST_QRD;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         // write the loaded position
         ST_PRD_W: begin
            pos_we   = 1'b1;
            state_in = ST_IDLE;
         end
         // read the three corner positions in turn
         ST_PRD_A: begin
            pos_addr = req_ff.corner_a;
            state_in = ST_PRD_B;
         end
         ST_PRD_B: begin
            pos_addr = req_ff.corner_b;
            pa_in    = pos_rdata;
            state_in = ST_PRD_C;
         end
         ST_PRD_C: begin
            pos_addr = req_ff.corner_c;
            pb_in    = pos_rdata;
            state_in = ST_EDGE;
         end
         ST_EDGE: begin
            for (int i = 0; i < 3; i++) begin
               e0_in[i] = (PosW+1)'($signed(pb_ff[3*PosW-1-PosW*i -: PosW]))
                        - (PosW+1)'($signed(pa_ff[3*PosW-1-PosW*i -: PosW]));
               e1_in[i] = (PosW+1)'($signed(pos_rdata[3*PosW-1-PosW*i -: PosW]))
                        - (PosW+1)'($signed(pa_ff[3*PosW-1-PosW*i -: PosW]));
            end
            state_in  = ST_CR0;
         end
         // cross product: two 25x25 multiplies per cycle, subtract next
         ST_CR0: begin
            pm0_in   = 64'(e0_ff[1] * e1_ff[2]);
            pm1_in   = 64'(e0_ff[2] * e1_ff[1]);
            state_in = ST_CR1;
         end
         ST_CR1: begin
            cr_in[0] = pm0_ff - pm1_ff;
            pm0_in   = 64'(e0_ff[2] * e1_ff[0]);
            pm1_in   = 64'(e0_ff[0] * e1_ff[2]);
            state_in = ST_CR2;
         end
         ST_CR2: begin
            cr_in[1] = pm0_ff - pm1_ff;
            pm0_in   = 64'(e0_ff[0] * e1_ff[1]);
            pm1_in   = 64'(e0_ff[1] * e1_ff[0]);
            state_in = ST_FN_START;
         end
         ST_FN_START: begin
            cr_in[2] = pm0_ff - pm1_ff;
            nvz      = pm0_ff - pm1_ff;
            norm_start = 1'b1;
            state_in = ST_FN_WAIT;
         end
         ST_FN_WAIT: begin
            if (norm_done) begin
               fn_in[0] = ux; fn_in[1] = uy; fn_in[2] = uz;
               ci_in    = 2'd0;
               state_in = ST_SRD;
            end
         end
         // read-modify-write each corner's sum in order A, B, C
         ST_SRD: begin
            sum_addr = cur_corner;
            state_in = ST_SWAIT;
         end
         ST_SWAIT: begin
            sum_addr = cur_corner;
            state_in = ST_SWR;
         end
         ST_SWR: begin
            sum_addr = cur_corner;
            if (t < TallyW'(FacesPerVertex)) begin
               sum_we    = 1'b1;
               sum_wdata = {SumW'(s0 + SumW'(fn_ff[0])),
                            SumW'(s1 + SumW'(fn_ff[1])),
                            SumW'(s2 + SumW'(fn_ff[2])), TallyW'(t + 1'b1)};
            end
            if (ci_ff == 2'd2) begin
               state_in = ST_IDLE;
            end else begin
               ci_in    = ci_ff + 2'd1;
               state_in = ST_SRD;
            end
         end
         ST_QRD:   state_in = ST_QWAIT;
         ST_QWAIT: begin
            nvx = 64'(s0); nvy = 64'(s1); nvz = 64'(s2);
            qtally_in  = t;
            norm_start = 1'b1;
            state_in   = ST_QN_WAIT;
         end
         ST_QN_WAIT: begin
            if (norm_done) begin
               rsp_in.normal_x = ux;
               rsp_in.normal_y = uy;
               rsp_in.normal_z = uz;
               rsp_in.faces_counted = qtally_ff;
               valid_in = 1'b1;
               state_in = ST_RSP;
            end
         end
         ST_RSP:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   assign busy      = (state_ff != ST_IDLE) || !store_ready;
   assign rsp_valid = valid_ff;
   assign rsp_word  = rsp_ff;

   // a response only follows a finished normalization
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_QN_WAIT))
      else $error("response without query");
   // tally never exceeds the cap
   assert property (@(posedge clock) disable iff (reset)
      sum_we |-> (sum_wdata[TallyW-1:0] <= TallyW'(FacesPerVertex)))
      else $error("tally overflow");
   // no item accepted while the clear sweep runs
   assert property (@(posedge clock) disable iff (reset)
      !store_ready |-> busy)
      else $error("accept during clear");

endmodule

>>> dv/mesh_vertex_normal_smoother_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_vertex_normal_smoother_checker: vertex normal predictor and comparator
// Watches accepted request words, keeps its own position, sum and tally
// stores, predicts each query answer and compares it field by field.
// ----------------------------------------------------------------------------
module mesh_vertex_normal_smoother_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  mvns_pkg::req_type req_word,
   input  logic              rsp_valid,
   input  mvns_pkg::rsp_type rsp_word,
   output int                fail_count,
   output int                pending_count
);
   import mvns_pkg::*;

   typedef logic signed [63:0] wide_t;

   logic signed [31:0] pos_mem [VertexCount][3];
   logic signed [31:0] sum_mem [VertexCount][3];
   logic [TallyW-1:0]  tally_mem [VertexCount];
   rsp_type            answer_q [$];

   // Integer square root, floor.
   function automatic logic [63:0] isqrt(logic [63:0] n);
      logic [63:0] root;
      logic [63:0] bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // Scale a vector to a Q1.14 unit vector; zero stays zero.
   function automatic void unit_vector(input wide_t v [3], output logic signed [31:0] o [3]);
      logic [63:0] mag [3];
      logic        neg [3];
      logic [63:0] maxm, len, q;
      int          s;
      maxm = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = v[i] < 0;
         mag[i] = neg[i] ? 64'(-v[i]) : 64'(v[i]);
         if (mag[i] > maxm) maxm = mag[i];
      end
      s = 0;
      while (s < 63 && (maxm >> s) >= (64'd1 << 30)) s++;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> s;
      len = isqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
      for (int i = 0; i < 3; i++) begin
         q = 0;
         if (len != 0) q = (mag[i] * OneQ14 + (len >> 1)) / len;
         o[i] = neg[i] ? -32'(q) : 32'(q);
      end
   endfunction

   // Apply one accepted word to the predicted stores.
   task automatic apply_word(input req_type w);
      int          c [3];
      wide_t       e0 [3], e1 [3], cr [3];
      logic signed [31:0] fn [3];
      wide_t       sv [3];
      rsp_type     r;
      case (w.kind)
         KIND_LOAD: begin
            pos_mem[w.vertex_index][0] = 32'(w.pos_x);
            pos_mem[w.vertex_index][1] = 32'(w.pos_y);
            pos_mem[w.vertex_index][2] = 32'(w.pos_z);
         end
         KIND_TRI: begin
            c[0] = int'(w.corner_a);
            c[1] = int'(w.corner_b);
            c[2] = int'(w.corner_c);
            for (int i = 0; i < 3; i++) begin
               e0[i] = wide_t'(pos_mem[c[1]][i]) - wide_t'(pos_mem[c[0]][i]);
               e1[i] = wide_t'(pos_mem[c[2]][i]) - wide_t'(pos_mem[c[0]][i]);
            end
            cr[0] = e0[1] * e1[2] - e0[2] * e1[1];
            cr[1] = e0[2] * e1[0] - e0[0] * e1[2];
            cr[2] = e0[0] * e1[1] - e0[1] * e1[0];
            unit_vector(cr, fn);
            for (int k = 0; k < 3; k++) begin
               if (tally_mem[c[k]] < FacesPerVertex) begin
                  for (int i = 0; i < 3; i++) sum_mem[c[k]][i] += fn[i];
                  tally_mem[c[k]]++;
               end
            end
         end
         KIND_QUERY: begin
            for (int i = 0; i < 3; i++) sv[i] = wide_t'(sum_mem[w.vertex_index][i]);
            unit_vector(sv, fn);
            r.normal_x = NormW'(fn[0]);
            r.normal_y = NormW'(fn[1]);
            r.normal_z = NormW'(fn[2]);
            r.faces_counted = tally_mem[w.vertex_index];
            answer_q.push_back(r);
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count    = 0;
      pending_count = 0;
      for (int v = 0; v < VertexCount; v++) begin
         tally_mem[v] = '0;
         for (int i = 0; i < 3; i++) begin
            pos_mem[v][i] = '0;
            sum_mem[v][i] = '0;
         end
      end
   end

   // Predict on accepted words, compare answers against the oldest one.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (answer_q.size() == 0) begin
               report_mismatch("unexpected answer", 1, 0);
            end else begin
               want = answer_q.pop_front();
               if (rsp_word.normal_x !== want.normal_x)
                  report_mismatch("normal_x", int'(rsp_word.normal_x),
                                  int'(want.normal_x));
               if (rsp_word.normal_y !== want.normal_y)
                  report_mismatch("normal_y", int'(rsp_word.normal_y),
                                  int'(want.normal_y));
               if (rsp_word.normal_z !== want.normal_z)
                  report_mismatch("normal_z", int'(rsp_word.normal_z),
                                  int'(want.normal_z));
               if (rsp_word.faces_counted !== want.faces_counted)
                  report_mismatch("faces_counted", int'(rsp_word.faces_counted),
                                  int'(want.faces_counted));
            end
         end
         if (start && !busy) apply_word(req_word);
      end
      pending_count = answer_q.size();
   end

endmodule

>>> dv/mesh_vertex_normal_smoother_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_vertex_normal_smoother_tb: stimulus and verdict for the smoother
// Loads small meshes, adds triangles, queries normals with bursty start
// timing; a side checker predicts and compares every answer.
// ----------------------------------------------------------------------------
module mesh_vertex_normal_smoother_tb;
   import mvns_pkg::*;

   localparam int ReqW = $bits(req_type);

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_word;
   logic    rsp_valid;
   rsp_type rsp_word;
   int      fail_count;
   int      pending_count;
   int      burst_left;
   int      loaded [$];

   mesh_vertex_normal_smoother i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_valid(rsp_valid), .rsp_word(rsp_word)
   );

   mesh_vertex_normal_smoother_checker i_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_valid(rsp_valid), .rsp_word(rsp_word),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Drive one word at a falling edge and hold it until busy is low after a rising edge.
   task automatic send_word(input req_type w);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 30)) @(negedge clock);
      end
      burst_left--;
      @(negedge clock);
      req_word <= w;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      start    <= 1'b0;
      req_word <= '0;
   endtask

   function automatic req_type rand_word();
      return req_type'(ReqW'({$urandom, $urandom, $urandom, $urandom}));
   endfunction

   function automatic logic signed [PosW-1:0] rand_pos(input int span);
      case ($urandom_range(0, 5))
         0:       return {1'b1, {(PosW-1){1'b0}}};
         1:       return {1'b0, {(PosW-1){1'b1}}};
         2:       return PosW'($urandom);
         default: return PosW'($urandom_range(0, 2 * span) - span);
      endcase
   endfunction

   task automatic load_vertex(input int v, input logic signed [PosW-1:0] x,
                              input logic signed [PosW-1:0] y,
                              input logic signed [PosW-1:0] z);
      req_type w;
      w = rand_word();
      w.kind = KIND_LOAD;
      w.vertex_index = VertexIdxW'(v);
      w.pos_x = x;
      w.pos_y = y;
      w.pos_z = z;
      send_word(w);
      loaded.push_back(v);
   endtask

   task automatic add_tri(input int a, input int b, input int c);
      req_type w;
      w = rand_word();
      w.kind = KIND_TRI;
      w.corner_a = VertexIdxW'(a);
      w.corner_b = VertexIdxW'(b);
      w.corner_c = VertexIdxW'(c);
      send_word(w);
   endtask

   task automatic query_vertex(input int v);
      req_type w;
      w = rand_word();
      w.kind = KIND_QUERY;
      w.vertex_index = VertexIdxW'(v);
      send_word(w);
   endtask

   function automatic int pick_loaded();
      return loaded[$urandom_range(0, loaded.size() - 1)];
   endfunction

   initial begin
      req_type w;
      int      base, span;
      reset      = 1'b1;
      start      = 1'b0;
      req_word   = '0;
      burst_left = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: extremes, degenerate face, repeated corner, full tally.
      load_vertex(0, 0, 0, 0);
      load_vertex(1, 24'sd256, 0, 0);
      load_vertex(2, 0, 24'sd256, 0);
      load_vertex(VertexCount - 1, {1'b1, 23'd0}, {1'b0, {23{1'b1}}}, {1'b1, 23'd0});
      load_vertex(4, {1'b0, {23{1'b1}}}, {1'b1, 23'd0}, {1'b0, {23{1'b1}}});
      query_vertex(0);
      add_tri(0, 1, 2);
      add_tri(0, 0, 1);
      add_tri(0, 4, VertexCount - 1);
      add_tri(4, VertexCount - 1, 1);
      repeat (4) add_tri(0, 2, 1);
      query_vertex(0);
      query_vertex(1);
      query_vertex(4);
      query_vertex(VertexCount - 1);
      query_vertex(3000);
      w = '1;
      w.kind = KIND_NONE;
      send_word(w);
      query_vertex(2);

      // Pause until every answer is back.
      while (pending_count != 0) @(negedge clock);

      // Random meshes: mostly loaded corners, a few wild words.
      for (int n = 0; n < 1330; n++) begin
         if (n % 150 == 0) begin
            base = $urandom_range(0, VertexCount - 16);
            span = ($urandom_range(0, 1) != 0) ? 4000 : 8388607;
            for (int k = 0; k < 4; k++)
               load_vertex(base + k, rand_pos(span), rand_pos(span), rand_pos(span));
         end
         case ($urandom_range(0, 19))
            0, 1, 2:
               load_vertex(($urandom_range(0, 3) == 0) ? $urandom_range(0, VertexCount - 1)
                           : pick_loaded(), rand_pos(span), rand_pos(span), rand_pos(span));
            3, 4, 5, 6, 7, 8, 9, 10:
               add_tri(pick_loaded(), pick_loaded(), pick_loaded());
            11, 12, 13, 14, 15, 16:
               query_vertex(($urandom_range(0, 7) == 0) ? $urandom_range(0, VertexCount - 1)
                            : pick_loaded());
            default: begin
               w = rand_word();
               w.kind = KIND_NONE;
               send_word(w);
            end
         endcase
      end

      while (pending_count != 0) @(negedge clock);
      repeat (400) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("simulation failed");
      $finish;
   end

endmodule

>>> mesh_vertex_normal_smoother.f
hdl/mvns_pkg.sv
hdl/mvns_normalizer.sv
hdl/mvns_store.sv
hdl/mesh_vertex_normal_smoother.sv
dv/mesh_vertex_normal_smoother_checker.sv
dv/mesh_vertex_normal_smoother_tb.sv
